>>> hdl/arbb_pkg.sv
// Shared types and constants of the affine rectangle bounding box block.
`timescale 1ns / 1ps
`default_nettype none

package arbb_pkg;

  localparam logic [2:0] REG_COEF_XX  = 3'd0;
  localparam logic [2:0] REG_COEF_XY  = 3'd1;
  localparam logic [2:0] REG_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_COEF_YX  = 3'd3;
  localparam logic [2:0] REG_COEF_YY  = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] off_x;
    logic [31:0] yx;
    logic [31:0] yy;
    logic [31:0] off_y;
  } coef_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [31:0] width;
    logic [31:0] height;
  } rect_t;

  typedef struct packed {
    logic [1:0][31:0] xs;
    logic [1:0][31:0] ys;
    logic             ovf;
  } corner_t;

  typedef struct packed {
    logic [1:0][63:0] xx;
    logic [1:0][63:0] xy;
    logic [1:0][63:0] yx;
    logic [1:0][63:0] yy;
    logic             ovf;
  } prod_t;

  typedef struct packed {
    logic [3:0][31:0] mx;
    logic [3:0][31:0] my;
    logic             ovf;
  } map_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] top;
    logic [30:0] width;
    logic [30:0] height;
    logic        ovf;
  } bbox_t;

endpackage

`default_nettype wire

>>> hdl/arbb_corner.sv
// Pipeline stage that forms the far corner coordinates with saturation.
`timescale 1ns / 1ps
`default_nettype none

module arbb_corner (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire arbb_pkg::rect_t  rect_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output arbb_pkg::corner_t     corner_o
);

  logic              v_q;
  arbb_pkg::corner_t corner_d, corner_q;
  logic [32:0]       sum_x, sum_y;
  logic              ovf_x, ovf_y;

  assign sum_x = {rect_i.left[31], rect_i.left} + {rect_i.width[31], rect_i.width};
  assign sum_y = {rect_i.top[31], rect_i.top} + {rect_i.height[31], rect_i.height};
  assign ovf_x = sum_x[32] ^ sum_x[31];
  assign ovf_y = sum_y[32] ^ sum_y[31];

  always_comb begin
    corner_d.xs[0] = rect_i.left;
    corner_d.ys[0] = rect_i.top;
    corner_d.xs[1] = ovf_x ? (sum_x[32] ? arbb_pkg::S32_MIN : arbb_pkg::S32_MAX)
                           : sum_x[31:0];
    corner_d.ys[1] = ovf_y ? (sum_y[32] ? arbb_pkg::S32_MIN : arbb_pkg::S32_MAX)
                           : sum_y[31:0];
    corner_d.ovf   = ovf_x | ovf_y;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      corner_q <= corner_d;
    end
  end

  assign valid_o  = v_q;
  assign corner_o = corner_q;

endmodule

`default_nettype wire

>>> hdl/arbb_mult.sv
// Pipeline stage with the eight coefficient by coordinate products.
`timescale 1ns / 1ps
`default_nettype none

module arbb_mult (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire arbb_pkg::coef_t   coef_i,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire arbb_pkg::corner_t corner_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output arbb_pkg::prod_t        prod_o
);

  logic            v_q;
  arbb_pkg::prod_t prod_d, prod_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod_d.xx[k] = 64'($signed(coef_i.xx) * $signed(corner_i.xs[k]));
      prod_d.xy[k] = 64'($signed(coef_i.xy) * $signed(corner_i.ys[k]));
      prod_d.yx[k] = 64'($signed(coef_i.yx) * $signed(corner_i.xs[k]));
      prod_d.yy[k] = 64'($signed(coef_i.yy) * $signed(corner_i.ys[k]));
    end
    prod_d.ovf = corner_i.ovf;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = v_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

>>> hdl/arbb_sum.sv
// Two pipeline stages: floored product sums, then offset add and saturation.
`timescale 1ns / 1ps
`default_nettype none

module arbb_sum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire arbb_pkg::coef_t  coef_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire arbb_pkg::prod_t  prod_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output arbb_pkg::map_t        map_o
);

  // stage A: floor((p1 + p2) / 2^16) per corner and axis
  logic             va_q;
  logic             ready_a;
  logic [3:0][48:0] shx_d, shx_q, shy_d, shy_q;
  logic             ovfa_q;
  logic [64:0]      sumx, sumy;

  always_comb begin
    shx_d = '0;
    shy_d = '0;
    for (int i = 0; i < 4; i++) begin
      sumx = {prod_i.xx[i / 2][63], prod_i.xx[i / 2]}
           + {prod_i.xy[i % 2][63], prod_i.xy[i % 2]};
      sumy = {prod_i.yx[i / 2][63], prod_i.yx[i / 2]}
           + {prod_i.yy[i % 2][63], prod_i.yy[i % 2]};
      shx_d[i] = sumx[64:16];
      shy_d[i] = sumy[64:16];
    end
  end

  // stage B: add offset, saturate to 32 bits
  logic           vb_q;
  logic           ready_b;
  arbb_pkg::map_t map_d, map_q;
  logic [49:0]    sx, sy;
  logic [3:0]     ox, oy;

  always_comb begin
    map_d = '0;
    ox    = '0;
    oy    = '0;
    for (int i = 0; i < 4; i++) begin
      sx = {shx_q[i][48], shx_q[i]} + {{18{coef_i.off_x[31]}}, coef_i.off_x};
      sy = {shy_q[i][48], shy_q[i]} + {{18{coef_i.off_y[31]}}, coef_i.off_y};
      ox[i] = !((&sx[49:31]) || !(|sx[49:31]));
      oy[i] = !((&sy[49:31]) || !(|sy[49:31]));
      map_d.mx[i] = ox[i] ? (sx[49] ? arbb_pkg::S32_MIN : arbb_pkg::S32_MAX) : sx[31:0];
      map_d.my[i] = oy[i] ? (sy[49] ? arbb_pkg::S32_MIN : arbb_pkg::S32_MAX) : sy[31:0];
    end
    map_d.ovf = ovfa_q | (|ox) | (|oy);
  end

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      shx_q  <= shx_d;
      shy_q  <= shy_d;
      ovfa_q <= prod_i.ovf;
    end
    if (ready_b && va_q) begin
      map_q <= map_d;
    end
  end

  assign valid_o = vb_q;
  assign map_o   = map_q;

endmodule

`default_nettype wire

>>> hdl/arbb_bbox.sv
// Two pipeline stages: min/max over the mapped corners, then extents.
`timescale 1ns / 1ps
`default_nettype none

module arbb_bbox (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire arbb_pkg::map_t  map_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output arbb_pkg::bbox_t      bbox_o
);

  function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
    smin = ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    smax = ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // stage A: reduce four corners per axis
  logic        va_q;
  logic        ready_a;
  logic [31:0] minx_q, maxx_q, miny_q, maxy_q;
  logic        ovfa_q;
  logic [31:0] minx_d, maxx_d, miny_d, maxy_d;

  assign minx_d = smin(smin(map_i.mx[0], map_i.mx[1]), smin(map_i.mx[2], map_i.mx[3]));
  assign maxx_d = smax(smax(map_i.mx[0], map_i.mx[1]), smax(map_i.mx[2], map_i.mx[3]));
  assign miny_d = smin(smin(map_i.my[0], map_i.my[1]), smin(map_i.my[2], map_i.my[3]));
  assign maxy_d = smax(smax(map_i.my[0], map_i.my[1]), smax(map_i.my[2], map_i.my[3]));

  // stage B: extents with saturation, output register
  logic            vb_q;
  logic            ready_b;
  arbb_pkg::bbox_t bbox_d, bbox_q;
  logic [32:0]     dx, dy;
  logic            odx, ody;

  assign dx  = {maxx_q[31], maxx_q} - {minx_q[31], minx_q};
  assign dy  = {maxy_q[31], maxy_q} - {miny_q[31], miny_q};
  assign odx = dx[32] | dx[31];
  assign ody = dy[32] | dy[31];

  always_comb begin
    bbox_d.left   = minx_q;
    bbox_d.top    = miny_q;
    bbox_d.width  = odx ? arbb_pkg::U31_MAX : dx[30:0];
    bbox_d.height = ody ? arbb_pkg::U31_MAX : dy[30:0];
    bbox_d.ovf    = ovfa_q | odx | ody;
  end

  assign ready_b = !vb_q || ready_i;
  assign ready_a = !va_q || ready_b;
  assign ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) begin
        va_q <= valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      minx_q <= minx_d;
      maxx_q <= maxx_d;
      miny_q <= miny_d;
      maxy_q <= maxy_d;
      ovfa_q <= map_i.ovf;
    end
    if (ready_b && va_q) begin
      bbox_q <= bbox_d;
    end
  end

  assign valid_o = vb_q;
  assign bbox_o  = bbox_q;

endmodule

`default_nettype wire

>>> hdl/affine_rect_bounding_box_top.sv
// Top level of the affine rectangle bounding box block.
`timescale 1ns / 1ps
`default_nettype none

// Maps the four corners of a rectangle through a six-coefficient Q16.16 affine
// transform and returns their bounding box. The block is a six-stage pipeline:
// corner sums, eight 32x32 products, floored product sums, offset add with
// saturation, min/max reduction, extents. It takes one word per cycle while
// the output is not held back by m_axis_tready. Every stage has its
// own valid bit and loads whenever it is empty or its successor moves, so
// bubbles are squeezed out while the output waits. Coefficients are written
// through the cfg channel, always ready; write them only while the pipeline
// is empty. Indexes above the last register are ignored.

module affine_rect_bounding_box_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // in_left, in_top, in_width, in_height
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_left, out_top, out_width, out_height, zero pad
  output logic [127:0]      m_axis_tdata,
  // overflow
  output logic              m_axis_tuser
);

  arbb_pkg::coef_t   coef_q;
  arbb_pkg::rect_t   rect;
  arbb_pkg::corner_t corner;
  arbb_pkg::prod_t   prod;
  arbb_pkg::map_t    map;
  arbb_pkg::bbox_t   bbox;
  logic              c_valid, c_ready, p_valid, p_ready, m_valid, m_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.xx    <= arbb_pkg::ONE_Q16;
      coef_q.xy    <= '0;
      coef_q.off_x <= '0;
      coef_q.yx    <= '0;
      coef_q.yy    <= arbb_pkg::ONE_Q16;
      coef_q.off_y <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        arbb_pkg::REG_COEF_XX:  coef_q.xx    <= cfg_data_i;
        arbb_pkg::REG_COEF_XY:  coef_q.xy    <= cfg_data_i;
        arbb_pkg::REG_OFFSET_X: coef_q.off_x <= cfg_data_i;
        arbb_pkg::REG_COEF_YX:  coef_q.yx    <= cfg_data_i;
        arbb_pkg::REG_COEF_YY:  coef_q.yy    <= cfg_data_i;
        arbb_pkg::REG_OFFSET_Y: coef_q.off_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rect.left   = s_axis_tdata[31:0];
  assign rect.top    = s_axis_tdata[63:32];
  assign rect.width  = s_axis_tdata[95:64];
  assign rect.height = s_axis_tdata[127:96];

  arbb_corner u_corner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .rect_i   (rect),
    .valid_o  (c_valid),
    .ready_i  (c_ready),
    .corner_o (corner)
  );

  arbb_mult u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef_q),
    .valid_i  (c_valid),
    .ready_o  (c_ready),
    .corner_i (corner),
    .valid_o  (p_valid),
    .ready_i  (p_ready),
    .prod_o   (prod)
  );

  arbb_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef_q),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .prod_i  (prod),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .map_o   (map)
  );

  arbb_bbox u_bbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .map_i   (map),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .bbox_o  (bbox)
  );

  assign m_axis_tdata = {2'b00, bbox.height, bbox.width, bbox.top, bbox.left};
  assign m_axis_tuser = bbox.ovf;

endmodule

`default_nettype wire
